[rtl/bhm_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the hash map.
package bhm_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int DEF_BUCKET_COUNT = 769;
  localparam int DEF_SLOTS_PER_BUCKET = 4;
  localparam int KEY_PAD_W = 32;
  localparam int MOD_BITS_PER_STEP = 4;
  localparam int MOD_STEPS = KEY_PAD_W / MOD_BITS_PER_STEP;

  localparam logic [1:0] OP_PUT = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [VAL_W-1:0] NOT_FOUND = '1;

  typedef struct packed {
    logic clr;
    logic load;
    logic step;
    logic rd;
    logic eval;
  } bhm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic out_busy;
  } bhm_stat_t;

endpackage

[rtl/bhm_ctrl.sv]
// Request sequencer: clearing pass, bucket reduction, bucket read and update.
module bhm_ctrl import bhm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_accept,
  input  bhm_stat_t stat,
  output bhm_cmd_t  cmd,
  output logic      in_ready
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_READ  = 5'b01000,
    S_EVAL  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_accept) begin
          cmd.load = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.step = 1'b1;
        if (stat.mod_last) state_next = S_READ;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.out_busy) begin
          cmd.eval = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[rtl/bhm_datapath.sv]
// Request registers, key-mod-bucket reduction, bucket memories, slot update and result register.
module bhm_datapath import bhm_pkg::*; #(
  parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
  input  logic             clk,
  input  logic             rst,
  input  bhm_cmd_t         cmd,
  output bhm_stat_t        stat,
  input  logic [1:0]       in_op,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_val,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [VAL_W-1:0] out_value
);

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int CW = $clog2(MOD_STEPS);
  localparam logic [BW:0] BC = (BW+1)'(BUCKET_COUNT);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKET_COUNT - 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(MOD_STEPS - 1);

  logic [1:0] op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] val;
  logic [KEY_PAD_W-1:0] kshift;
  logic [CW-1:0] cnt;
  logic [BW-1:0] rem, rem_next;
  logic [BW-1:0] clr_addr;

  logic [SLOTS_PER_BUCKET-1:0] valid_mem [BUCKET_COUNT];
  logic [SLOTS_PER_BUCKET*KEY_W-1:0] key_mem [BUCKET_COUNT];
  logic [SLOTS_PER_BUCKET*VAL_W-1:0] val_mem [BUCKET_COUNT];

  logic [SLOTS_PER_BUCKET-1:0] rd_valid, wr_valid;
  logic [SLOTS_PER_BUCKET*KEY_W-1:0] rd_key, wr_key;
  logic [SLOTS_PER_BUCKET*VAL_W-1:0] rd_val, wr_val;

  logic [SLOTS_PER_BUCKET-1:0] hit;
  logic [SW-1:0] hit_idx, free_idx;
  logic any_hit, any_free;
  logic [1:0] status_next;
  logic [VAL_W-1:0] value_next;

  assign stat.clr_last = (clr_addr == LAST_ROW);
  assign stat.mod_last = (cnt == LAST_STEP);
  assign stat.out_busy = out_valid && !out_ready;

  always_comb begin
    logic [BW:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < MOD_BITS_PER_STEP; i++) begin
      r = {r[BW-1:0], kshift[KEY_PAD_W-1-i]};
      if (r >= BC) r = r - BC;
    end
    rem_next = r[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      key <= in_key;
      val <= in_val;
      kshift <= {1'b0, in_key};
      cnt <= '0;
      rem <= '0;
    end else if (cmd.step) begin
      kshift <= kshift << MOD_BITS_PER_STEP;
      cnt <= cnt + 1'b1;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_comb begin
    any_hit = 1'b0;
    any_free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      hit[s] = rd_valid[s] && (rd_key[s*KEY_W +: KEY_W] == key);
      if (hit[s]) begin
        any_hit = 1'b1;
        hit_idx = SW'(s);
      end
      if (!rd_valid[s]) begin
        any_free = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  always_comb begin
    wr_valid = rd_valid;
    wr_key = rd_key;
    wr_val = rd_val;
    status_next = ST_ABSENT;
    value_next = NOT_FOUND;
    unique case (op)
      OP_PUT: begin
        if (any_hit) begin
          wr_val[hit_idx*VAL_W +: VAL_W] = val;
          status_next = ST_DONE;
        end else if (any_free) begin
          wr_valid[free_idx] = 1'b1;
          wr_key[free_idx*KEY_W +: KEY_W] = key;
          wr_val[free_idx*VAL_W +: VAL_W] = val;
          status_next = ST_DONE;
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_GET: begin
        if (any_hit) begin
          value_next = rd_val[hit_idx*VAL_W +: VAL_W];
          status_next = ST_DONE;
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          wr_valid[hit_idx] = 1'b0;
          status_next = ST_DONE;
        end
      end
      default: status_next = ST_ABSENT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      valid_mem[clr_addr] <= '0;
    end else if (cmd.eval) begin
      valid_mem[rem] <= wr_valid;
    end
    if (cmd.rd) rd_valid <= valid_mem[rem];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) key_mem[rem] <= wr_key;
    if (cmd.rd) rd_key <= key_mem[rem];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) val_mem[rem] <= wr_val;
    if (cmd.rd) rd_val <= val_mem[rem];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.eval) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_status <= status_next;
      out_value <= value_next;
    end
  end

endmodule

[rtl/bucketed_hash_map.sv]
// Bucketed key-to-value map: top level joining sequencer and datapath to the stream ports.
// Sequence from input transfer to result valid: 8 mod-reduction steps, 4 bits each,
//   then bucket read, then slot compare and write-back into the output register.
// Requests do not overlap: s_tready is high only when idle; the mod-BUCKET_COUNT reduction loop
//   dominates each request, and a result held by m_tready low delays the write-back.
// Reset: synchronous; afterwards a clearing pass writes every bucket's valid row, one row per
//   cycle, with s_tready low until it ends.
module bucketed_hash_map import bhm_pkg::*; #(
  parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
  parameter int SLOTS_PER_BUCKET = DEF_SLOTS_PER_BUCKET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // key[30:0], value[62:31], zero[63]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_value[31:0]
  output logic [1:0]  m_tuser    // status[1:0]
);

  bhm_cmd_t cmd;
  bhm_stat_t stat;
  logic in_accept;

  assign in_accept = s_tvalid && s_tready;

  bhm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_accept(in_accept),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  bhm_datapath #(
    .BUCKET_COUNT    (BUCKET_COUNT),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (s_tuser),
    .in_key    (s_tdata[KEY_W-1:0]),
    .in_val    (s_tdata[KEY_W+VAL_W-1:KEY_W]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(m_tuser),
    .out_value (m_tdata)
  );

endmodule
